### rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge once reset is released.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: property violated");

// Implication written out by the caller: antecedent and consequent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");

`endif

### rtl/stbs_pkg.sv
// Types and constants of the sorted table binary search block.
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ENTRY_WIDTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int VALUE_W     = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ENTRY_COUNT    = 1'b0;
	localparam cfg_idx_t REG_SIGNED_COMPARE = 1'b1;

	typedef logic op_t;
	localparam op_t OP_LOAD   = 1'b0;
	localparam op_t OP_SEARCH = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] entry_count;
		logic             signed_compare;
	} cfg_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

	typedef struct packed {
		logic                   we;
		logic [IDX_W-1:0]       waddr;
		logic [ENTRY_WIDTH-1:0] wdata;
		logic                   re;
		logic [IDX_W-1:0]       raddr;
	} ram_ctl_t;

endpackage

### rtl/stbs_if.sv
// Handshake interfaces for the request, response and configuration channels.
interface stbs_req_if import stbs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [IDX_W-1:0]   entry_index;
	logic [VALUE_W-1:0] entry_value;
	logic [VALUE_W-1:0] search_key;

	modport source (output valid, operation, entry_index, entry_value, search_key,
		input ready);
	modport sink (input valid, operation, entry_index, entry_value, search_key,
		output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [IDX_W-1:0] match_index;

	modport source (output valid, found, match_index, input ready);
	modport sink (input valid, found, match_index, output ready);
endinterface

interface stbs_cfg_if import stbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/sorted_table_binary_search_core.sv
// Top level of the sorted table binary search block.
//
//  channel | role   | request contents
//  req     | sink   | operation, entry_index, entry_value, search_key
//  rsp     | source | found, match_index
//  cfg     | sink   | index (0 entry_count, 1 signed_compare), data
//
// A load request is written into the table RAM directly.
// A search request runs a halving loop after acceptance: each halving step
// reads the RAM in S_READ and compares in S_COMP; the last one uses S_FINAL.
// The request side is not ready while a search runs; a finished result sits
// in the output register, and a later result waits in the sequencer for it.
// Reset clears the configuration and control state; table contents are kept
// undefined until loaded. Configuration requests are always accepted.
`include "assert_macros.svh"

module sorted_table_binary_search_core import stbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	stbs_req_if.sink   req,
	stbs_rsp_if.source rsp,
	stbs_cfg_if.sink   cfg
);

	cfg_t                   cfg_q;
	cmp_res_t               cmp_res;
	ram_ctl_t               ram_ctl;
	logic [ENTRY_WIDTH-1:0] key;
	logic [ENTRY_WIDTH-1:0] rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ENTRY_COUNT: begin
					cfg_q.entry_count <= cfg.data[CNT_W-1:0];
				end
				REG_SIGNED_COMPARE: begin
					cfg_q.signed_compare <= cfg.data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	stbs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg_q),
		.cmp    (cmp_res),
		.key    (key),
		.ram    (ram_ctl)
	);

	stbs_cmp u_cmp (
		.key            (key),
		.entry          (rdata),
		.signed_compare (cfg_q.signed_compare),
		.res            (cmp_res)
	);

	stbs_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_ctl.we),
		.waddr (ram_ctl.waddr),
		.wdata (ram_ctl.wdata),
		.re    (ram_ctl.re),
		.raddr (ram_ctl.raddr),
		.rdata (rdata)
	);

	// A search keeps the request side closed for at least the next cycle.
	`ASSERT_IMPLY(a_search_blocks, clk, arst_n,
		req.valid && req.ready && (req.operation == OP_SEARCH), ##1 !req.ready)
	// A new result only appears at the end of a search, never out of idle.
	`ASSERT_IMPLY(a_result_after_search, clk, arst_n, $rose(rsp.valid), !$past(req.ready))
	// A miss always reports index zero.
	`ASSERT_ALWAYS(a_miss_index_zero, clk, arst_n,
		!(rsp.valid && !rsp.found) || (rsp.match_index == '0))

endmodule

### rtl/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/stbs_cmp.sv
// Shared key compare unit: unsigned or two's complement ordering.
module stbs_cmp import stbs_pkg::*; (
	input  logic [ENTRY_WIDTH-1:0] key,
	input  logic [ENTRY_WIDTH-1:0] entry,
	input  logic                   signed_compare,
	output cmp_res_t               res
);

	logic [ENTRY_WIDTH-1:0] key_ord;
	logic [ENTRY_WIDTH-1:0] entry_ord;

	// Flipping the sign bit turns a two's complement order into an unsigned one.
	always_comb begin
		key_ord   = key;
		entry_ord = entry;
		key_ord[ENTRY_WIDTH-1]   = key[ENTRY_WIDTH-1] ^ signed_compare;
		entry_ord[ENTRY_WIDTH-1] = entry[ENTRY_WIDTH-1] ^ signed_compare;
		res.eq = (key_ord == entry_ord);
		res.lt = (key_ord < entry_ord);
	end

endmodule

### rtl/stbs_seq.sv
// Search sequencer: accepts requests, steps the halving loop, holds the result.
module stbs_seq import stbs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	stbs_req_if.sink               req,
	stbs_rsp_if.source             rsp,
	input  cfg_t                   cfg,
	input  cmp_res_t               cmp,
	output logic [ENTRY_WIDTH-1:0] key,
	output ram_ctl_t               ram
);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_COMP, S_FINAL, S_DONE} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       low_q;
	logic [IDX_W-1:0]       high_q;
	logic [IDX_W-1:0]       mid_q;
	logic [ENTRY_WIDTH-1:0] key_q;
	logic                   res_found_q;
	logic [IDX_W-1:0]       res_idx_q;
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [IDX_W-1:0]       out_idx_q;

	logic             accept;
	logic             more;
	logic             publish;
	logic [IDX_W-1:0] mid;
	logic [CNT_W-1:0] count_eff;

	always_comb begin
		req.ready = (state_q == S_IDLE);
		accept    = req.valid && req.ready;
		more      = (low_q < high_q);
		mid       = low_q + ((high_q - low_q) >> 1);
		publish   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
		if (cfg.entry_count > CNT_W'(TABLE_DEPTH)) begin
			count_eff = CNT_W'(TABLE_DEPTH);
		end else begin
			count_eff = cfg.entry_count;
		end
		ram.we    = accept && (req.operation == OP_LOAD);
		ram.waddr = req.entry_index;
		ram.wdata = req.entry_value[ENTRY_WIDTH-1:0];
		ram.re    = (state_q == S_READ);
		ram.raddr = more ? mid : low_q;
		key       = key_q;
		rsp.valid       = out_valid_q;
		rsp.found       = out_found_q;
		rsp.match_index = out_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_q       <= '0;
			high_q      <= '0;
			mid_q       <= '0;
			key_q       <= '0;
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req.operation == OP_SEARCH)) begin
						key_q       <= req.search_key[ENTRY_WIDTH-1:0];
						low_q       <= '0;
						high_q      <= IDX_W'(count_eff - CNT_W'(1));
						res_found_q <= 1'b0;
						res_idx_q   <= '0;
						if (count_eff == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					mid_q <= mid;
					if (more) begin
						state_q <= S_COMP;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_COMP: begin
					if (cmp.eq) begin
						res_found_q <= 1'b1;
						res_idx_q   <= mid_q;
						state_q     <= S_DONE;
					end else begin
						if (cmp.lt) begin
							high_q <= mid_q;
						end else begin
							low_q <= mid_q + IDX_W'(1);
						end
						state_q <= S_READ;
					end
				end
				S_FINAL: begin
					if (cmp.eq) begin
						res_found_q <= 1'b1;
						res_idx_q   <= low_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// The result waits here until the output register is free.
					if (publish) begin
						out_found_q <= res_found_q;
						out_idx_q   <= res_idx_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### test/sorted_table_binary_search_core_tb.sv
// Self-checking testbench for the sorted table binary search core.
`timescale 1ns / 1ps

module sorted_table_binary_search_core_tb;
	import stbs_pkg::*;

	localparam int ITEM_TARGET   = 1800;
	localparam int MAX_GAP       = 14;
	localparam int HOLD_CYCLES   = 300;
	// Longest search plus some margin, waited out before any register write.
	localparam int SETTLE_CYCLES = 2 * IDX_W + 3 + 8;
	localparam int OVERSIZE_COUNT = 2047;

	// Tracks the table and registers and predicts the answer to each search.
	class lookup_scoreboard;
		typedef struct {
			logic             found;
			logic [IDX_W-1:0] match_index;
		} lookup_t;

		logic [ENTRY_WIDTH-1:0] entry_words [TABLE_DEPTH];
		logic [CNT_W-1:0]       count_reg;
		logic                   signed_mode;
		lookup_t                pending_lookups [$];
		int                     mismatch_count;

		function new();
			count_reg      = '0;
			signed_mode    = 1'b0;
			mismatch_count = 0;
		endfunction

		function void set_reg(cfg_idx_t r, logic [CFG_DATA_W-1:0] d);
			case (r)
				REG_ENTRY_COUNT:    count_reg = d[CNT_W-1:0];
				REG_SIGNED_COMPARE: signed_mode = d[0];
				default: ;
			endcase
		endfunction

		// Flipping the sign bit turns a two's complement order into an unsigned one.
		function logic [ENTRY_WIDTH-1:0] rank_of(logic [ENTRY_WIDTH-1:0] v);
			return v ^ {signed_mode, {(ENTRY_WIDTH-1){1'b0}}};
		endfunction

		function lookup_t predict_lookup(logic [VALUE_W-1:0] key_in);
			lookup_t                r;
			int                     n, lo, hi, mid;
			logic [ENTRY_WIDTH-1:0] k, e;
			r.found       = 1'b0;
			r.match_index = '0;
			k = rank_of(key_in[ENTRY_WIDTH-1:0]);
			n = count_reg;
			if (n > TABLE_DEPTH)
				n = TABLE_DEPTH;
			if (n == 0)
				return r;
			lo = 0;
			hi = n - 1;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				e = rank_of(entry_words[mid]);
				if (k == e) begin
					r.found       = 1'b1;
					r.match_index = mid[IDX_W-1:0];
					return r;
				end
				if (k < e)
					hi = mid;
				else
					lo = mid + 1;
			end
			if (k == rank_of(entry_words[lo])) begin
				r.found       = 1'b1;
				r.match_index = lo[IDX_W-1:0];
			end
			return r;
		endfunction

		function void note_request(op_t op, logic [IDX_W-1:0] idx,
				logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] key_in);
			if (op == OP_LOAD)
				entry_words[idx] = val[ENTRY_WIDTH-1:0];
			else
				pending_lookups.push_back(predict_lookup(key_in));
		endfunction

		function void flag(string what);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%s", what);
		endfunction

		function void check_response(logic found, logic [IDX_W-1:0] match_index);
			lookup_t x;
			if (pending_lookups.size() == 0) begin
				flag($sformatf("unexpected result: found %0d match_index %0d",
					found, match_index));
				return;
			end
			x = pending_lookups.pop_front();
			if (found !== x.found || match_index !== x.match_index)
				flag($sformatf("mismatch: found exp %0d got %0d, match_index exp %0d got %0d",
					x.found, found, x.match_index, match_index));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stbs_req_if req_ch ();
	stbs_rsp_if rsp_ch ();
	stbs_cfg_if cfg_ch ();

	sorted_table_binary_search_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	lookup_scoreboard sb = new();
	int   items_sent = 0;
	bit   tx_quiet = 1'b0;
	bit   rx_quiet = 1'b0;
	bit   hold_go = 1'b0;
	bit   rsp_hold = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL sorted_table_binary_search_core");
		$finish;
	end

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.operation   = OP_LOAD;
		req_ch.entry_index = '0;
		req_ch.entry_value = '0;
		req_ch.search_key  = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = REG_ENTRY_COUNT;
		cfg_ch.data        = '0;
	end

	// Result side: random stalls per result, plus one long hold-off.
	initial begin : rsp_side
		int gap;
		gap = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold || gap > 0) begin
				rsp_ch.ready = 1'b0;
				if (!rsp_hold)
					gap--;
			end else begin
				rsp_ch.ready = 1'b1;
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_response(rsp_ch.found, rsp_ch.match_index);
				gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end
		end
	end

	initial begin : rsp_hold_off
		wait (hold_go);
		@(negedge clk);
		rsp_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rsp_hold = 1'b0;
	end

	task automatic push_request(op_t op, logic [IDX_W-1:0] idx,
			logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] key_in);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.operation   = op;
		req_ch.entry_index = idx;
		req_ch.entry_value = val;
		req_ch.search_key  = key_in;
		req_ch.valid       = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(op, idx, val, key_in);
		items_sent++;
	endtask

	task automatic load_entry(logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] val);
		push_request(OP_LOAD, idx, val, $urandom);
	endtask

	task automatic search_key(logic [VALUE_W-1:0] key_in);
		push_request(OP_SEARCH, IDX_W'($urandom), $urandom, key_in);
	endtask

	// Lowers the request valid, then waits for every result and for the core to settle.
	task automatic drain_lookups();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t r, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = r;
		cfg_ch.data  = d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(r, d);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Loads entries 0..n-1 ascending in the chosen order, duplicates allowed.
	task automatic load_sorted(int n, int unsigned step_max, bit as_signed);
		longint unsigned r, span;
		logic [31:0]     v;
		span = longint'(n) * step_max;
		if ($urandom_range(0, 3) == 0)
			r = 0;
		else
			r = $urandom_range(0, 32'hFFFF_FFFF - span[31:0]);
		for (int i = 0; i < n; i++) begin
			v = r[31:0] ^ (as_signed ? 32'h8000_0000 : 32'h0);
			load_entry(i[IDX_W-1:0], v);
			r += $urandom_range(0, step_max);
		end
	endtask

	function automatic logic [VALUE_W-1:0] pick_key(int n);
		int          lim;
		logic [31:0] e;
		lim = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
		if (lim == 0)
			return $urandom;
		e = sb.entry_words[$urandom_range(0, lim - 1)];
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			7: return e + 1;
			8: return e - 1;
			default: return e;
		endcase
	endfunction

	initial begin : stimulus
		int          n, m, phase;
		int unsigned step_max;
		bit          as_signed, full_signed;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty table straight after reset, then with the count written as zero.
		search_key(32'h0000_0000);
		drain_lookups();
		write_reg(REG_SIGNED_COMPARE, 0);
		write_reg(REG_ENTRY_COUNT, 0);
		search_key(32'hFFFF_FFFF);
		load_entry(0, 32'h0000_0000);
		load_entry(1, 32'h0000_0005);
		load_entry(2, 32'h7FFF_FFFF);
		load_entry(3, 32'hFFFF_FFFF);
		load_entry(IDX_W'(TABLE_DEPTH - 1), 32'h8000_0000);
		drain_lookups();
		write_reg(REG_ENTRY_COUNT, 4);
		search_key(32'h0000_0000);
		search_key(32'h0000_0005);
		search_key(32'h7FFF_FFFF);
		search_key(32'hFFFF_FFFF);
		search_key(32'h0000_0006);
		drain_lookups();
		write_reg(REG_ENTRY_COUNT, 1);
		search_key(32'h0000_0000);
		search_key(32'h0000_0005);
		drain_lookups();
		// The same words compared as signed are out of order.
		write_reg(REG_ENTRY_COUNT, 4);
		write_reg(REG_SIGNED_COMPARE, 1);
		search_key(32'hFFFF_FFFF);
		search_key(32'h0000_0005);
		search_key(32'h8000_0000);

		// Fill the whole table so that any count can be searched afterwards.
		full_signed = 1'($urandom_range(0, 1));
		load_sorted(TABLE_DEPTH, 4_000_000, full_signed);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain_lookups();
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			as_signed = 1'($urandom_range(0, 1));
			if (phase == 0) begin
				n = TABLE_DEPTH;
				as_signed = full_signed;
				tx_quiet = 1'b1;
			end else if (phase == 1) begin
				n = OVERSIZE_COUNT;
				as_signed = full_signed;
			end else begin
				case ($urandom_range(0, 19))
					0: n = 0;
					1: n = 1;
					2: n = TABLE_DEPTH;
					3: n = OVERSIZE_COUNT;
					default: n = $urandom_range(2, 40);
				endcase
			end
			write_reg(REG_SIGNED_COMPARE, CFG_DATA_W'(as_signed));
			write_reg(REG_ENTRY_COUNT, n[CFG_DATA_W-1:0]);
			if (n > 0 && n < TABLE_DEPTH) begin
				case ($urandom_range(0, 2))
					0: step_max = 3;
					1: step_max = 1000;
					default: step_max = 1 << 24;
				endcase
				load_sorted(n, step_max, as_signed);
			end
			// The result side stops for a long time while requests keep coming.
			if (phase == 0)
				hold_go = 1'b1;
			m = $urandom_range(15, 45);
			repeat (m) begin
				if ($urandom_range(0, 9) < 8)
					search_key(pick_key(n));
				else if (n > 0 && $urandom_range(0, 1) == 0)
					load_entry(IDX_W'($urandom_range(0,
						((n > TABLE_DEPTH) ? TABLE_DEPTH : n) - 1)), $urandom);
				else
					load_entry(IDX_W'($urandom), $urandom);
			end
			phase++;
		end

		drain_lookups();
		if (sb.mismatch_count == 0 && sb.pending_lookups.size() == 0)
			$display("PASS sorted_table_binary_search_core");
		else
			$display("FAIL sorted_table_binary_search_core");
		$finish;
	end

endmodule
